/* rtl/assert_macros.svh */
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SFOD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define SFOD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/sfod_pkg.sv */
// package: types, constants and face table of the orientation detector
`default_nettype none
package sfod_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int FRACTION_BITS = 12;
   localparam int THR_WIDTH     = 13;
   localparam int FACE_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = THR_WIDTH;

   // signed working width: holds samples, one g and the threshold with headroom
   localparam int WIDEST_OPERAND =
      (SAMPLE_WIDTH > FRACTION_BITS + 1)
         ? ((SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH)
         : ((FRACTION_BITS + 1 > THR_WIDTH) ? FRACTION_BITS + 1 : THR_WIDTH);
   localparam int CALC_WIDTH = WIDEST_OPERAND + 3;

   localparam logic signed [CALC_WIDTH-1:0] ONE_G = CALC_WIDTH'(1) <<< FRACTION_BITS;

   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1638);

   typedef logic [FACE_WIDTH-1:0] face_type;

   localparam face_type FACE_UNKNOWN = 3'd0;
   localparam face_type FACE_POS_Z   = 3'd1;
   localparam face_type FACE_POS_X   = 3'd2;
   localparam face_type FACE_POS_Y   = 3'd3;
   localparam face_type FACE_NEG_Y   = 3'd4;
   localparam face_type FACE_NEG_X   = 3'd5;
   localparam face_type FACE_NEG_Z   = 3'd6;
   localparam int FACE_COUNT = 6;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_THRESHOLD  = 1'b0,
      CSR_START_FACE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_ZERO = 2'b00,
      DIR_POS  = 2'b01,
      DIR_NEG  = 2'b10
   } dir_type;

   typedef struct packed {
      dir_type x;
      dir_type y;
      dir_type z;
   } face_vec_type;

   // per-axis comparison results against each expected direction
   typedef struct packed {
      logic near_neg;
      logic near_zero;
      logic near_pos;
      logic fail_neg;
      logic fail_zero;
      logic fail_pos;
   } axis_flags_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] accel_x;
      logic signed [SAMPLE_WIDTH-1:0] accel_y;
      logic signed [SAMPLE_WIDTH-1:0] accel_z;
   } req_payload_type;

   typedef struct packed {
      face_type face;
      logic     face_changed;
   } rsp_payload_type;

   function automatic face_vec_type face_dir(input face_type face);
      face_vec_type vec;
      vec.x = DIR_ZERO;
      vec.y = DIR_ZERO;
      vec.z = DIR_ZERO;
      unique case (face)
         FACE_POS_Z: vec.z = DIR_POS;
         FACE_POS_X: vec.x = DIR_POS;
         FACE_POS_Y: vec.y = DIR_POS;
         FACE_NEG_Y: vec.y = DIR_NEG;
         FACE_NEG_X: vec.x = DIR_NEG;
         FACE_NEG_Z: vec.z = DIR_NEG;
         default: ;
      endcase
      return vec;
   endfunction

   function automatic logic signed [CALC_WIDTH-1:0] abs_val(
      input logic signed [CALC_WIDTH-1:0] v
   );
      return v[CALC_WIDTH-1] ? -v : v;
   endfunction

endpackage
`default_nettype wire

/* rtl/six_face_orientation_detector_core.sv */
// Six-face orientation detector: one accelerometer sample in, current face out.
//
// req channel: one three-axis sample (signed, FRACTION_BITS fraction bits) per
// transaction, taken when req_valid is high and req_stall is low.
// rsp channel: one result per sample (face 0..6 and a face_changed flag), held
// steady while rsp_stall is high.
// csr port: index 0 sets the hysteresis threshold, index 1 loads the current
// face directly (a value of 7 loads unknown). Write only while no sample is in
// flight.
// Path: sample stage register, then result register.
// Throughput: one sample per cycle while the result is not held; the
// current-face register is updated in the same cycle as the sample is evaluated,
// so consecutive samples chain through it with no gap.
// Stall: while the result register is held, the sample stage holds too and
// req_stall rises once that stage is occupied.
// Reset: both stages empty, threshold 1638 (0.4 g), current face unknown.
`default_nettype none
module six_face_orientation_detector_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire sfod_pkg::req_payload_type               req_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output sfod_pkg::rsp_payload_type                    rsp_data,
   input  wire logic                                    csr_write_enable,
   input  wire logic [sfod_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [sfod_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   logic                          s1_valid_ff, s1_valid_in;
   sfod_pkg::req_payload_type     s1_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   sfod_pkg::rsp_payload_type     rsp_data_ff;
   logic [sfod_pkg::THR_WIDTH-1:0] thr_ff, thr_in;
   sfod_pkg::face_type            face_ff, face_in;

   logic                          s1_advance;
   sfod_pkg::axis_flags_type      flags_x, flags_y, flags_z;
   sfod_pkg::rsp_payload_type     result;
   sfod_pkg::face_type            start_face;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;

   sfod_axis_check u_axis_x (.sample(s1_data_ff.accel_x), .thr(thr_ff), .flags(flags_x));
   sfod_axis_check u_axis_y (.sample(s1_data_ff.accel_y), .thr(thr_ff), .flags(flags_y));
   sfod_axis_check u_axis_z (.sample(s1_data_ff.accel_z), .thr(thr_ff), .flags(flags_z));

   sfod_face_update u_face_update (
      .flags_x      (flags_x),
      .flags_y      (flags_y),
      .flags_z      (flags_z),
      .current_face (face_ff),
      .result       (result)
   );

   assign start_face = csr_wdata[sfod_pkg::FACE_WIDTH-1:0];

   always_comb begin
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
      thr_in       = thr_ff;
      face_in      = face_ff;
      if (s1_valid_ff && s1_advance) begin
         face_in = result.face;
      end
      if (csr_write_enable) begin
         unique case (sfod_pkg::csr_index_type'(csr_index))
            sfod_pkg::CSR_THRESHOLD: thr_in = csr_wdata[sfod_pkg::THR_WIDTH-1:0];
            sfod_pkg::CSR_START_FACE: begin
               face_in = (start_face > sfod_pkg::FACE_NEG_Z) ? sfod_pkg::FACE_UNKNOWN
                                                             : start_face;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= sfod_pkg::THR_RESET;
         face_ff      <= sfod_pkg::FACE_UNKNOWN;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         face_ff      <= face_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_data_ff <= req_data;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* rtl/sfod_axis_check.sv */
// one axis: tolerance tests of a sample against the three expected directions
`default_nettype none
module sfod_axis_check (
   input  wire logic signed [sfod_pkg::SAMPLE_WIDTH-1:0] sample,
   input  wire logic [sfod_pkg::THR_WIDTH-1:0]           thr,
   output sfod_pkg::axis_flags_type                      flags
);

   logic signed [sfod_pkg::CALC_WIDTH-1:0] a_ext;
   logic signed [sfod_pkg::CALC_WIDTH-1:0] thr_ext;
   logic signed [sfod_pkg::CALC_WIDTH-1:0] lim;
   logic signed [sfod_pkg::CALC_WIDTH-1:0] dist_zero;
   logic signed [sfod_pkg::CALC_WIDTH-1:0] dist_pos;
   logic signed [sfod_pkg::CALC_WIDTH-1:0] dist_neg;

   assign a_ext   = {{(sfod_pkg::CALC_WIDTH-sfod_pkg::SAMPLE_WIDTH){sample[sfod_pkg::SAMPLE_WIDTH-1]}},
                     sample};
   assign thr_ext = {{(sfod_pkg::CALC_WIDTH-sfod_pkg::THR_WIDTH){1'b0}}, thr};
   // may go negative when the threshold exceeds one g
   assign lim     = sfod_pkg::ONE_G - thr_ext;

   assign dist_zero = sfod_pkg::abs_val(a_ext);
   assign dist_pos  = sfod_pkg::abs_val(sfod_pkg::ONE_G - a_ext);
   assign dist_neg  = sfod_pkg::abs_val(-sfod_pkg::ONE_G - a_ext);

   always_comb begin
      flags.fail_zero = (a_ext < -thr_ext) || (a_ext > thr_ext);
      flags.fail_pos  = a_ext < lim;
      flags.fail_neg  = a_ext > -lim;
      flags.near_zero = dist_zero < lim;
      flags.near_pos  = dist_pos < lim;
      flags.near_neg  = dist_neg < lim;
   end

endmodule
`default_nettype wire

/* rtl/sfod_face_update.sv */
// decides the next face from the three axis results and the current face
`default_nettype none
module sfod_face_update (
   input  wire sfod_pkg::axis_flags_type  flags_x,
   input  wire sfod_pkg::axis_flags_type  flags_y,
   input  wire sfod_pkg::axis_flags_type  flags_z,
   input  wire sfod_pkg::face_type        current_face,
   output sfod_pkg::rsp_payload_type      result
);

   function automatic logic axis_fail(input sfod_pkg::axis_flags_type f,
                                      input sfod_pkg::dir_type d);
      logic r;
      case (d)
         sfod_pkg::DIR_POS: r = f.fail_pos;
         sfod_pkg::DIR_NEG: r = f.fail_neg;
         default:           r = f.fail_zero;
      endcase
      return r;
   endfunction

   function automatic logic axis_near(input sfod_pkg::axis_flags_type f,
                                      input sfod_pkg::dir_type d);
      logic r;
      case (d)
         sfod_pkg::DIR_POS: r = f.near_pos;
         sfod_pkg::DIR_NEG: r = f.near_neg;
         default:           r = f.near_zero;
      endcase
      return r;
   endfunction

   sfod_pkg::face_vec_type old_vec;
   logic                   update;
   sfod_pkg::face_type     next_face;

   assign old_vec = sfod_pkg::face_dir(current_face);
   assign update  = axis_fail(flags_x, old_vec.x) || axis_fail(flags_y, old_vec.y) ||
                    axis_fail(flags_z, old_vec.z);

   always_comb begin
      sfod_pkg::face_vec_type vec;
      next_face = current_face;
      // later faces override earlier ones: highest candidate wins
      for (int i = 1; i <= sfod_pkg::FACE_COUNT; i++) begin
         vec = sfod_pkg::face_dir(sfod_pkg::FACE_WIDTH'(i));
         if (update && axis_near(flags_x, vec.x) && axis_near(flags_y, vec.y) &&
             axis_near(flags_z, vec.z)) begin
            next_face = sfod_pkg::FACE_WIDTH'(i);
         end
      end
   end

   assign result.face         = next_face;
   assign result.face_changed = next_face != current_face;

endmodule
`default_nettype wire

/* rtl/sfod_checker.sv */
// port-level checks on the orientation detector, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sfod_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire sfod_pkg::rsp_payload_type rsp_data
);

   logic rsp_known;

   assign rsp_known = rsp_data.face != sfod_pkg::FACE_UNKNOWN;

   // a held result keeps its contents
   `SFOD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp moved")

   // the stored face never leaves the legal range
   `SFOD_ASSERT(a_face_range, rsp_valid |-> rsp_data.face <= sfod_pkg::FACE_NEG_Z, "bad face")

   // a change always lands on a real face
   `SFOD_ASSERT(a_change_known, rsp_valid && rsp_data.face_changed |-> rsp_known, "unknown face")

   // the input side only backs up behind a waiting result
   `SFOD_ASSERT(a_stall_cause, !rsp_valid |-> !req_stall, "req_stall without a held result")

   // reset empties the pipeline
   `SFOD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

bind six_face_orientation_detector_core sfod_checker u_sfod_checker (.*);
`default_nettype wire
